### rtl/yuvssd_pkg.sv
// Shared types, codes and a helper function for the YUV 4:2:0 plane SSD accumulator.
// No dependencies; compiled first.
package yuvssd_pkg;

  localparam int PIX_W      = 8;
  localparam int SQ_W       = 2 * PIX_W;
  localparam int ACC_W      = 40;
  localparam int PIXCNT_W   = 24;
  localparam int RUN_W      = 56;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int WIDTH_REG_W  = 13;
  localparam int HEIGHT_REG_W = 12;
  localparam int RST_FRAME_WIDTH  = 1920;
  localparam int RST_FRAME_HEIGHT = 1080;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_t;

  // One queue entry: squared difference plus end-of-plane tag, plane id and plane pixel count
  typedef struct packed {
    logic [SQ_W-1:0]     sq;
    logic                last;
    plane_t              plane;
    logic [PIXCNT_W-1:0] pixels;
  } pix_entry_t;

  // Even value, at least 2, at most maxv
  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
    int unsigned r;
    r = v & ~32'd1;
    if (r < 32'd2) r = 32'd2;
    if (r > maxv) r = maxv;
    return r;
  endfunction

endpackage

### rtl/yuvssd_front.sv
// Front end: frame geometry registers, pixel squaring and end-of-plane tagging.
// Depends on yuvssd_pkg.
module yuvssd_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 2304
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [yuvssd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [yuvssd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [yuvssd_pkg::PIX_W-1:0]       in_src_pixel,
  input  logic [yuvssd_pkg::PIX_W-1:0]       in_cmp_pixel,
  output logic                               push,
  output yuvssd_pkg::pix_entry_t             push_entry
);
  import yuvssd_pkg::*;

  localparam int W_W   = $clog2(MAX_WIDTH + 1);
  localparam int H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int RST_W = int'(clamp_dim(RST_FRAME_WIDTH, MAX_WIDTH));
  localparam int RST_H = int'(clamp_dim(RST_FRAME_HEIGHT, MAX_HEIGHT));
  localparam int RST_CNT = RST_W * RST_H;

  logic [W_W-1:0]   width_r, width_nxt;
  logic [H_W-1:0]   height_r, height_nxt;
  logic [CNT_W-1:0] luma_cnt_r, luma_cnt_nxt;
  logic [CNT_W-1:0] pos_r;
  plane_t           plane_r;

  logic [CNT_W-1:0] plane_cnt;
  logic [CNT_W:0]   pos_inc;
  logic             is_last;
  logic [PIX_W-1:0] diff;

  // Clamped geometry and luma count are settled at write time
  always_comb begin
    width_nxt    = width_r;
    height_nxt   = height_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAME_WIDTH: begin
          width_nxt = W_W'(clamp_dim(32'(cfg_wdata[WIDTH_REG_W-1:0]), MAX_WIDTH));
        end
        CFG_FRAME_HEIGHT: begin
          height_nxt = H_W'(clamp_dim(32'(cfg_wdata[HEIGHT_REG_W-1:0]), MAX_HEIGHT));
        end
        default: begin
        end
      endcase
    end
    luma_cnt_nxt = CNT_W'(width_nxt) * CNT_W'(height_nxt);
  end

  always_comb begin
    plane_cnt = (plane_r == PLANE_Y) ? luma_cnt_r : (luma_cnt_r >> 2);
    pos_inc   = {1'b0, pos_r} + (CNT_W+1)'(1);
    is_last   = (pos_inc >= {1'b0, plane_cnt});
    diff      = (in_src_pixel > in_cmp_pixel) ? (in_src_pixel - in_cmp_pixel)
                                              : (in_cmp_pixel - in_src_pixel);
    push                = in_valid && in_ready;
    push_entry.sq       = SQ_W'(diff) * SQ_W'(diff);
    push_entry.last     = is_last;
    push_entry.plane    = plane_r;
    push_entry.pixels   = PIXCNT_W'(plane_cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= W_W'(RST_W);
      height_r   <= H_W'(RST_H);
      luma_cnt_r <= CNT_W'(RST_CNT);
      pos_r      <= '0;
      plane_r    <= PLANE_Y;
    end else begin
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      luma_cnt_r <= luma_cnt_nxt;
      if (push) begin
        if (is_last) begin
          pos_r <= '0;
          case (plane_r)
            PLANE_Y: plane_r <= PLANE_U;
            PLANE_U: plane_r <= PLANE_V;
            default: plane_r <= PLANE_Y;
          endcase
        end else begin
          pos_r <= pos_inc[CNT_W-1:0];
        end
      end
    end
  end

endmodule

### rtl/yuvssd_fifo.sv
// Short queue of tagged squared differences between front and back ends.
// Depends on yuvssd_pkg.
module yuvssd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  yuvssd_pkg::pix_entry_t push_entry,
  output logic                   full,
  input  logic                   pop,
  output logic                   empty,
  output yuvssd_pkg::pix_entry_t head
);
  import yuvssd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pix_entry_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### rtl/yuvssd_back.sv
// Back end: plane accumulator, per-plane saturating running totals, result register.
// Depends on yuvssd_pkg.
module yuvssd_back #(
  parameter int TOTAL_BITS = 56
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                empty,
  input  yuvssd_pkg::pix_entry_t              head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_plane_id,
  output logic [yuvssd_pkg::ACC_W-1:0]        out_plane_ssd,
  output logic [yuvssd_pkg::PIXCNT_W-1:0]     out_plane_pixels,
  output logic [yuvssd_pkg::RUN_W-1:0]        out_running_ssd,
  output logic                                out_frame_done
);
  import yuvssd_pkg::*;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

  logic [ACC_W-1:0]      acc_r;
  logic [ACC_W:0]        acc_sum;
  logic [ACC_W-1:0]      acc_nxt;

  // Closed-plane stage
  logic                  b_vld_r;
  plane_t                b_plane_r;
  logic [ACC_W-1:0]      b_ssd_r;
  logic [PIXCNT_W-1:0]   b_pix_r;

  logic [TOTAL_BITS-1:0] run_r [3];
  logic [TOTAL_BITS-1:0] run_sel;
  logic [TOTAL_BITS:0]   run_sum;
  logic [TOTAL_BITS-1:0] run_nxt;

  logic                  out_valid_r;
  logic                  out_free, b_adv, b_free;

  always_comb begin
    out_free = !out_valid_r || out_ready;
    b_adv    = b_vld_r && out_free;
    b_free   = !b_vld_r || b_adv;
    pop      = !empty && (!head.last || b_free);

    acc_sum  = {1'b0, acc_r} + (ACC_W+1)'(head.sq);
    acc_nxt  = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];

    case (b_plane_r)
      PLANE_Y: run_sel = run_r[0];
      PLANE_U: run_sel = run_r[1];
      default: run_sel = run_r[2];
    endcase
    run_sum = {1'b0, run_sel} + (TOTAL_BITS+1)'(b_ssd_r);
    run_nxt = run_sum[TOTAL_BITS] ? TOTAL_MAX : run_sum[TOTAL_BITS-1:0];
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      b_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        run_r[i] <= '0;
      end
    end else begin
      if (pop) begin
        acc_r <= head.last ? '0 : acc_nxt;
      end
      b_vld_r <= (b_vld_r && !b_adv) || (pop && head.last);
      if (b_adv) begin
        for (int i = 0; i < 3; i++) begin
          if (b_plane_r == plane_t'(i)) run_r[i] <= run_nxt;
        end
      end
      out_valid_r <= b_adv || (out_valid_r && !out_ready);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      b_plane_r <= head.plane;
      b_ssd_r   <= acc_nxt;
      b_pix_r   <= head.pixels;
    end
    if (b_adv) begin
      out_plane_id     <= b_plane_r;
      out_plane_ssd    <= b_ssd_r;
      out_plane_pixels <= b_pix_r;
      out_running_ssd  <= RUN_W'(run_nxt);
      out_frame_done   <= (b_plane_r == PLANE_V);
    end
  end

endmodule

### rtl/yuv420_plane_ssd_accumulator_unit.sv
// Top level of the YUV 4:2:0 plane SSD accumulator.
// Depends on yuvssd_pkg, yuvssd_front, yuvssd_fifo and yuvssd_back.
//
// Sum-of-squared-differences engine for PSNR measurement of 4:2:0 planar
// video. Pixel pairs (source, compared) stream in raster order, Y plane of
// frame_width x frame_height, then U and V planes of a quarter of that each.
// Every pair's squared difference is added to the open plane's 40-bit
// accumulator (saturating). On the last pixel of a plane one result beat
// comes out: plane id, the plane's SSD, its pixel count (MSE divisor) and a
// per-plane running total across frames that saturates at 2^TOTAL_BITS-1;
// frame_done marks the V plane. Dividing and the log10 step stay in software.
// Throughput is one pixel pair per clock, sustained: the front end squares
// and tags each pair in the cycle it is accepted and writes it into a
// 4-entry queue; the back end drains one entry per clock into the
// accumulator unless a stalled result holds a last entry. A result beat
// moves via the closed-plane stage into the out_ port register after its
// plane's last pixel is accepted, and waits there while the stream keeps
// going; in_ready drops only once the queue fills behind a stalled result.
// Geometry: odd dimensions lose their low bit, and values are clamped to
// 2..MAX_WIDTH / 2..MAX_HEIGHT. cfg_ready is always high; the plane pixel
// count is registered at the write, so a pixel may follow a write in the
// very next cycle. Write registers only while idle; a mid-plane write takes
// effect at once and closes the plane on the first pixel at or past the new
// end. Index 0 is frame_width, 1 is frame_height, other indexes are ignored.
module yuv420_plane_ssd_accumulator_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 2304,
  parameter int TOTAL_BITS = 56
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [yuvssd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [yuvssd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // pixel pair stream
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [yuvssd_pkg::PIX_W-1:0]      in_src_pixel,
  input  logic [yuvssd_pkg::PIX_W-1:0]      in_cmp_pixel,
  // per-plane results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_plane_id,
  output logic [yuvssd_pkg::ACC_W-1:0]      out_plane_ssd,
  output logic [yuvssd_pkg::PIXCNT_W-1:0]   out_plane_pixels,
  output logic [yuvssd_pkg::RUN_W-1:0]      out_running_ssd,
  output logic                              out_frame_done
);
  import yuvssd_pkg::*;

  localparam int QUEUE_DEPTH = 4;

  logic       push, pop, q_full, q_empty;
  pix_entry_t push_entry, q_head;

  // Registers are plain flops with no side effects: writes always land
  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;

  yuvssd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_src_pixel (in_src_pixel),
    .in_cmp_pixel (in_cmp_pixel),
    .push         (push),
    .push_entry   (push_entry)
  );

  yuvssd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  yuvssd_back #(
    .TOTAL_BITS (TOTAL_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .empty            (q_empty),
    .head             (q_head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_plane_id     (out_plane_id),
    .out_plane_ssd    (out_plane_ssd),
    .out_plane_pixels (out_plane_pixels),
    .out_running_ssd  (out_running_ssd),
    .out_frame_done   (out_frame_done)
  );

endmodule

### rtl/yuvssd_checker.sv
// Port-level checks for the YUV 4:2:0 plane SSD accumulator, bound to the top level.
// Depends on yuv420_plane_ssd_accumulator_unit port list.
module yuvssd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_plane_id,
  input logic [39:0] out_plane_ssd,
  input logic        out_frame_done
);

  // Plane ids are Y, U or V only
  a_plane_id_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_plane_id == 2'd0 || out_plane_id == 2'd1 || out_plane_id == 2'd2))
    else $error("out_plane_id out of range");

  // frame_done marks exactly the V plane
  a_frame_done_v: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_done == (out_plane_id == 2'd2)))
    else $error("frame_done does not match V plane");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_plane_id) && $stable(out_plane_ssd))
    else $error("result beat changed while stalled");

  // Plane order check: a Y result follows a V result
  a_plane_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_plane_id == 2'd2 ##1 out_valid |-> out_plane_id == 2'd0)
    else $error("plane after V is not Y");

endmodule

bind yuv420_plane_ssd_accumulator_unit yuvssd_checker u_yuvssd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_plane_id   (out_plane_id),
  .out_plane_ssd  (out_plane_ssd),
  .out_frame_done (out_frame_done)
);
